// ----- src/equal_power_panner_smoothed_assert.svh -----
// assertion macros shared by the panner modules
// expects clk and rst_n in the including module's scope
`ifndef EQUAL_POWER_PANNER_SMOOTHED_ASSERT_SVH
`define EQUAL_POWER_PANNER_SMOOTHED_ASSERT_SVH

// same-cycle implication
`define EPPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/epps_pkg.sv -----
// types, constants and gain table of the equal-power panner
// no dependencies
package epps_pkg;

  localparam int SMOOTH_SAMPLES = 256;
  localparam int TABLE_BITS     = 8;
  localparam int RAMP_SHIFT     = $clog2(SMOOTH_SAMPLES);
  localparam int STEPS_W        = $clog2(SMOOTH_SAMPLES + 1);
  localparam int IDX_W          = TABLE_BITS + 1;
  localparam int ROM_DEPTH      = (1 << TABLE_BITS) + 1;
  localparam int GAIN_W         = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam real PI_VAL        = 3.14159265358979323846;
  localparam real ROM_ANGLE_STEP = PI_VAL / (2.0 ** (TABLE_BITS + 1));

  typedef struct packed {
    logic signed [15:0] mono_in;
    logic signed [15:0] pan_target;
  } epps_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } epps_out_t;

  typedef struct packed {
    logic signed [15:0] mono_in;
    logic [IDX_W-1:0]   idx_l;
    logic [IDX_W-1:0]   idx_r;
  } epps_work_t;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef gain_t gain_rom_t [ROM_DEPTH];

  function automatic gain_rom_t build_gain_rom();
    gain_rom_t rom;
    real x;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x = k * ROM_ANGLE_STEP;
      rom[k] = GAIN_W'($rtoi(32767.0 * $sin(x) + 0.5));
    end
    return rom;
  endfunction

  localparam gain_rom_t GAIN_ROM = build_gain_rom();

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/epps_queue.sv -----
// short register queue between the front and back parts of the panner
// depends on epps_pkg
`include "equal_power_panner_smoothed_assert.svh"

module epps_queue
  import epps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  epps_work_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output epps_work_t rd_data,
  output logic       empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  epps_work_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `EPPS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

// ----- src/epps_front.sv -----
// front part: accepts beats, tracks the smoothed pan and derives table indexes
// depends on epps_pkg
`include "equal_power_panner_smoothed_assert.svh"

module epps_front
  import epps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  epps_in_t   in_data,
  output epps_work_t work
);

  logic signed [31:0] pan_now_r, pan_now_nxt;
  logic signed [15:0] pan_goal_r, pan_goal_nxt;
  logic signed [31:0] pan_step_r, pan_step_nxt;
  logic [STEPS_W-1:0] steps_left_r, steps_left_nxt;

  logic               ramp_start;
  logic signed [33:0] diff;
  logic signed [33:0] diff_shift;
  logic signed [33:0] sum;
  logic [STEPS_W-1:0] steps_dec;
  logic [15:0]        pan_hi;
  logic [15:0]        pan_u;
  logic [IDX_W-1:0]   idx_r;

  assign ramp_start = (in_data.pan_target != pan_goal_r) && (steps_left_r == '0);

  always_comb begin
    diff       = {{2{in_data.pan_target[15]}}, in_data.pan_target, 16'h0000}
               - {{2{pan_now_r[31]}}, pan_now_r};
    diff_shift = diff >>> RAMP_SHIFT;

    pan_goal_nxt   = pan_goal_r;
    pan_step_nxt   = pan_step_r;
    steps_left_nxt = steps_left_r;
    pan_now_nxt    = pan_now_r;
    if (ramp_start) begin
      pan_goal_nxt   = in_data.pan_target;
      pan_step_nxt   = sat32(diff_shift);
      steps_left_nxt = STEPS_W'(SMOOTH_SAMPLES);
    end

    sum       = {{2{pan_now_r[31]}}, pan_now_r} + {{2{pan_step_nxt[31]}}, pan_step_nxt};
    steps_dec = steps_left_nxt - 1'b1;
    if (steps_left_nxt != '0) begin
      steps_left_nxt = steps_dec;
      if (steps_dec == '0) begin
        pan_now_nxt = {pan_goal_nxt, 16'h0000};
      end else begin
        pan_now_nxt = sat32(sum);
      end
    end
  end

  // index from the pan after this beat's advance
  always_comb begin
    pan_hi           = pan_now_nxt[31:16];
    pan_u            = {~pan_hi[15], pan_hi[14:0]};
    idx_r            = {1'b0, pan_u[15 -: TABLE_BITS]};
    work.mono_in     = in_data.mono_in;
    work.idx_r       = idx_r;
    work.idx_l       = IDX_W'(ROM_DEPTH - 1) - idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_now_r    <= '0;
      pan_goal_r   <= '0;
      pan_step_r   <= '0;
      steps_left_r <= '0;
    end else if (accept) begin
      pan_now_r    <= pan_now_nxt;
      pan_goal_r   <= pan_goal_nxt;
      pan_step_r   <= pan_step_nxt;
      steps_left_r <= steps_left_nxt;
    end
  end

  `EPPS_ASSERT_NOW(a_rest_on_goal, steps_left_r == '0, (pan_now_r[31:16] == pan_goal_r) && (pan_now_r[15:0] == '0), "pan off goal with no ramp")
  `EPPS_ASSERT_NOW(a_steps_bound, 1'b1, steps_left_r <= STEPS_W'(SMOOTH_SAMPLES), "ramp counter out of range")
  `EPPS_ASSERT_NEXT(a_ramp_load, accept && ramp_start, steps_left_r == STEPS_W'(SMOOTH_SAMPLES - 1), "ramp start did not load counter")

endmodule

// ----- src/epps_back.sv -----
// back part: gain table lookup, multiply and result register
// depends on epps_pkg
`include "equal_power_panner_smoothed_assert.svh"

module epps_back
  import epps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  epps_work_t work,
  input  logic       q_empty,
  output logic       q_pop,
  output epps_out_t  out_data,
  output logic       empty,
  input  logic       pop
);

  logic               va_r, va_nxt;
  logic               vb_r, vb_nxt;
  logic               en_a, en_b;
  logic signed [15:0] sample_a_r;
  gain_t              gain_l_a_r, gain_r_a_r;
  epps_out_t          out_b_r;
  logic signed [32:0] prod_l, prod_r;

  assign en_b   = !vb_r || pop;
  assign en_a   = !va_r || en_b;
  assign q_pop  = en_a && !q_empty;
  assign va_nxt = en_a ? !q_empty : va_r;
  assign vb_nxt = en_b ? va_r : vb_r;

  assign prod_l = sample_a_r * $signed({1'b0, gain_l_a_r});
  assign prod_r = sample_a_r * $signed({1'b0, gain_r_a_r});

  assign out_data = out_b_r;
  assign empty    = !vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      sample_a_r <= work.mono_in;
      gain_l_a_r <= GAIN_ROM[work.idx_l];
      gain_r_a_r <= GAIN_ROM[work.idx_r];
    end
    if (en_b) begin
      out_b_r.left_out  <= prod_l[30:15];
      out_b_r.right_out <= prod_r[30:15];
    end
  end

  `EPPS_ASSERT_NEXT(a_pop_fills_a, q_pop, va_r, "popped beat lost before gain stage")

endmodule

// ----- src/equal_power_panner_smoothed.sv -----
// equal-power stereo panner with smoothed pan, top level
// depends on epps_pkg, epps_queue, epps_front, epps_back
//
// Input channel: in_data carries a Q1.15 mono sample and a Q1.15 target pan.
// A beat is taken at a rising edge with push high and full low. Result channel:
// out_data holds the left/right pair of the oldest waiting result while empty
// is low; it is taken at a rising edge with pop high and empty low.
// Each beat gives exactly one result, in order. The pan ramps toward a new
// target over SMOOTH_SAMPLES beats and snaps onto it at the end of the ramp.
// A beat passes the queue, the gain lookup register and the multiply result
// register. Throughput: one beat per cycle while results are taken, set by the
// pan update in the front part and the two-stage lookup/multiply back part.
// When the receiver stalls, the back stages hold and the two-entry queue fills;
// full rises once it holds two beats. Reset (rst_n low, synchronous) empties
// the queue and the stages and returns the pan to center with no ramp.
module equal_power_panner_smoothed
  import epps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  epps_in_t  in_data,
  output logic      empty,
  input  logic      pop,
  output epps_out_t out_data
);

  logic       accept;
  epps_work_t work_in;
  epps_work_t work_out;
  logic       q_empty;
  logic       q_pop;

  assign accept = push && !full;

  epps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .work    (work_in)
  );

  epps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (work_in),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (work_out),
    .empty   (q_empty)
  );

  epps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .work     (work_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
